// File: src/first_max_index_search_unit_assert.svh
`ifndef FIRST_MAX_INDEX_SEARCH_UNIT_ASSERT_SVH
`define FIRST_MAX_INDEX_SEARCH_UNIT_ASSERT_SVH
// Assertion helpers
`define FMIS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define FMIS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: src/fmis_pkg.sv
package fmis_pkg;
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_RD_TOP,
      ST_CHK_TOP,
      ST_CHK_PREV,
      ST_SEARCH,
      ST_WAIT_MID,
      ST_CHK_LO,
      ST_SEND
   } state_type;

   localparam int unsigned IDX_W = 10;
   localparam int unsigned VAL_W = 64;

   function automatic logic dbl_eq(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
      logic a_nan;
      logic b_nan;
      logic both_zero;
      a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
      b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
      both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
      dbl_eq = !a_nan && !b_nan && (both_zero || (a == b));
   endfunction
endpackage

// File: src/first_max_index_search_unit.sv
// first_max_index_search_unit
// Loads an ascending array of IEEE doubles and returns the index of the
// first element equal to the last (maximum) element.
// Input channel req_: one element per transfer, req_tdata = value_bits,
// req_tlast marks the final element. Elements are written to a single-port-
// write RAM, one per cycle, so loading runs at one element per cycle.
// Result channel rsp_: one transfer per array, tdata = first_max_index
// (bits 9:0), tuser = overflowed.
// After the last element the block stops accepting and searches: it reads
// the last element, compares the one before it, then halves the range,
// waiting on the registered RAM read in each halving step. Elements beyond
// MAX_ELEMENTS are dropped and flag overflowed.
// Reset clears the count, overflow flag and state; the RAM is not cleared
// since only written entries are read. While rsp_tready is low, the result
// holds in its output register and no new element is accepted.
module first_max_index_search_unit #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // value_bits[63:0]
   input  logic        req_tlast,  // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // first_max_index[9:0], zero fill
   output logic        rsp_tuser   // overflowed
);
   import fmis_pkg::*;

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam logic [CW-1:0] MAXC = CW'(MAX_ELEMENTS);

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [AW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [63:0]   top_ff, top_in;
   logic [AW-1:0] res_ff, res_in;
   logic          rd_ovf_ff, rd_ovf_in;

   logic          wr_en;
   logic [AW-1:0] rd_addr;
   logic [63:0]   rd_data;
   logic          accept;
   logic [AW:0]   sum;

   fmis_ram #(.WIDTH(64), .DEPTH(MAX_ELEMENTS)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(req_tdata),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_tready = (state_ff == ST_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign wr_en      = accept && (count_ff < MAXC);
   assign sum        = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign rsp_tvalid = (state_ff == ST_SEND);
   assign rsp_tdata  = {6'd0, IDX_W'({{(32){1'b0}}, res_ff})};
   assign rsp_tuser  = rd_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      top_ff    <= top_in;
      res_ff    <= res_in;
      rd_ovf_ff <= rd_ovf_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      top_in    = top_ff;
      res_in    = res_ff;
      rd_ovf_in = rd_ovf_ff;
      rd_addr   = mid_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (count_ff < MAXC) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  rd_ovf_in = ovf_ff || !(count_ff < MAXC);
                  if (count_ff < MAXC) begin
                     hi_in = count_ff[AW-1:0];
                  end else begin
                     hi_in = AW'(count_ff - 1'b1);
                  end
                  if (count_ff == '0) begin
                     res_in   = '0;
                     state_in = ST_SEND;
                  end else begin
                     state_in = ST_RD_TOP;
                  end
               end
            end
         end
         ST_RD_TOP: begin
            // hi holds last index
            rd_addr  = hi_ff;
            mid_in   = hi_ff - 1'b1;
            state_in = ST_CHK_TOP;
         end
         ST_CHK_TOP: begin
            top_in  = rd_data;
            rd_addr = mid_ff;
            if (hi_ff == '0) begin
               res_in   = '0;
               state_in = ST_SEND;
            end else begin
               state_in = ST_CHK_PREV;
            end
         end
         ST_CHK_PREV: begin
            if (!dbl_eq(rd_data, top_ff)) begin
               res_in   = hi_ff;
               state_in = ST_SEND;
            end else begin
               lo_in    = '0;
               hi_in    = mid_ff;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (hi_ff - lo_ff > AW'(1)) begin
               mid_in   = sum[AW:1];
               rd_addr  = sum[AW:1];
               state_in = ST_WAIT_MID;
            end else if (hi_ff == lo_ff) begin
               res_in   = hi_ff;
               state_in = ST_SEND;
            end else begin
               rd_addr  = lo_ff;
               state_in = ST_CHK_LO;
            end
         end
         ST_WAIT_MID: begin
            if (dbl_eq(rd_data, top_ff)) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff;
            end
            state_in = ST_SEARCH;
         end
         ST_CHK_LO: begin
            res_in   = dbl_eq(rd_data, top_ff) ? lo_ff : hi_ff;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_tready) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

`include "first_max_index_search_unit_assert.svh"
   `FMIS_ASSERT(a_cnt_bound, clock, reset, count_ff <= MAXC, "count above depth")
   `FMIS_ASSERT(a_no_acc_busy, clock, reset, (state_ff != ST_LOAD) |-> !req_tready, "ready while busy")
   `FMIS_ASSERT(a_bounds, clock, reset, (state_ff == ST_SEARCH) |-> (lo_ff <= hi_ff), "lo above hi")
   `FMIS_ASSERT(a_send_clear, clock, reset, (rsp_tvalid && rsp_tready) |=> (count_ff == '0 && !ovf_ff), "state not cleared")
endmodule

// File: src/fmis_ram.sv
module fmis_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: verif/first_max_index_search_unit_test.sv
module first_max_index_search_unit_test;
   import fmis_pkg::*;

   localparam int MAX_ELEMENTS = 1024;
   localparam int CYCLE_LIMIT = 2000000;
   localparam logic [63:0] POS_ZERO = 64'h0000_0000_0000_0000;
   localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
   localparam logic [63:0] QNAN = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] NEG_INF = 64'hFFF0_0000_0000_0000;
   localparam logic [63:0] ONE = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] TWO = 64'h4000_0000_0000_0000;

   typedef struct packed {
      logic [63:0] value_bits;
      logic        is_last;
   } element_type;

   typedef struct packed {
      logic [9:0] first_max_index;
      logic       overflowed;
   } max_index_type;

   typedef struct {
      logic [63:0]   value_bits;
      logic          is_last;
      logic          typed;
      max_index_type result;
   } table_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;

   logic [63:0]   stored_values [MAX_ELEMENTS];
   int unsigned   stored_count;
   logic          dropped_seen;
   max_index_type expected_indexes [$];
   logic          typed_flags [$];
   max_index_type typed_indexes [$];
   element_type   pending_elements [$];
   int            mismatch_count;
   int            cycle_count;
   int            send_idle_pct;
   int            recv_idle_pct;

   first_max_index_search_unit #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic doubles_equal(logic [63:0] a, logic [63:0] b);
      logic a_nan;
      logic b_nan;
      a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 0);
      b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 0);
      if (a_nan || b_nan) return 1'b0;
      if (a[62:0] == 0 && b[62:0] == 0) return 1'b1;
      return a == b;
   endfunction

   function automatic logic [9:0] find_first_max(int unsigned len);
      logic [63:0] top;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      if (len <= 1) return 0;
      top = stored_values[len-1];
      if (!doubles_equal(stored_values[len-2], top)) return 10'(len - 1);
      hi = len - 2;
      lo = 0;
      while (hi - lo > 1) begin
         mid = (hi + lo) / 2;
         if (doubles_equal(stored_values[mid], top)) hi = mid;
         else lo = mid;
      end
      if (hi == lo) return 10'(hi);
      if (doubles_equal(stored_values[lo], top)) return 10'(lo);
      return 10'(hi);
   endfunction

   task automatic predict_element(element_type e, logic typed, max_index_type typed_result);
      max_index_type r;
      if (stored_count < MAX_ELEMENTS) begin
         stored_values[stored_count] = e.value_bits;
         stored_count++;
      end else begin
         dropped_seen = 1'b1;
      end
      if (e.is_last) begin
         r.first_max_index = find_first_max(stored_count);
         r.overflowed = dropped_seen;
         expected_indexes.push_back(r);
         typed_flags.push_back(typed);
         typed_indexes.push_back(typed_result);
         stored_count = 0;
         dropped_seen = 1'b0;
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch: %s got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      mismatch_count++;
   endtask

   // sender
   always @(posedge clock) begin
      element_type e;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            void'(pending_elements.pop_front());
         end
         if (!req_tvalid || req_tready) begin
            if (pending_elements.size() > 0 &&
                  $urandom_range(99, 0) >= send_idle_pct) begin
               e = pending_elements[0];
               req_tvalid <= 1'b1;
               req_tdata <= e.value_bits;
               req_tlast <= e.is_last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      max_index_type want;
      max_index_type typed_want;
      logic typed;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_indexes.size() == 0) begin
               report_mismatch("unexpected transfer, index", rsp_tdata[9:0], -1);
            end else begin
               want = expected_indexes.pop_front();
               typed = typed_flags.pop_front();
               typed_want = typed_indexes.pop_front();
               if (typed) want = typed_want;
               if (rsp_tdata[9:0] !== want.first_max_index)
                  report_mismatch("first_max_index", rsp_tdata[9:0], want.first_max_index);
               if (rsp_tuser !== want.overflowed)
                  report_mismatch("overflowed", rsp_tuser, want.overflowed);
               if (rsp_tdata[15:10] !== 6'd0)
                  report_mismatch("tdata fill", rsp_tdata[15:10], 0);
            end
         end
         rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   task automatic queue_element(logic [63:0] v, logic last, logic typed, max_index_type r);
      element_type e;
      e.value_bits = v;
      e.is_last = last;
      predict_element(e, typed, r);
      pending_elements.push_back(e);
   endtask

   task automatic wait_drained();
      while (pending_elements.size() > 0) @(posedge clock);
   endtask

   function automatic logic [63:0] random_double();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(7, 0))
         0: v = POS_ZERO;
         1: v = NEG_ZERO;
         2: v = QNAN;
         3: v = POS_INF;
         4: v = NEG_INF;
         default: ;
      endcase
      return v;
   endfunction

   // negative head with a tail of equal maxima, or an all-random array, content drawn at random
   task automatic queue_random_array(output int queued);
      int len;
      int dup;
      int k;
      logic [63:0] v;
      logic [63:0] top;
      max_index_type none;
      none = '0;
      case ($urandom_range(19, 0))
         0: len = 1;
         default: len = $urandom_range(24, 2);
      endcase
      queued = len;
      if ($urandom_range(9, 0) == 0) begin
         for (k = 0; k < len; k++) queue_element(random_double(), k == len - 1, 1'b0, none);
      end else begin
         dup = $urandom_range(len, 1);
         top = {1'b0, 11'($urandom_range(11'h7FE, 1)), $urandom, 20'($urandom)};
         if ($urandom_range(7, 0) == 0) top = ($urandom_range(1, 0)) ? POS_ZERO : NEG_ZERO;
         if ($urandom_range(9, 0) == 0) top = POS_INF;
         for (k = 0; k < len; k++) begin
            if (k >= len - dup) begin
               v = top;
               if (top[62:0] == 0 && $urandom_range(1, 0)) v = {~top[63], top[62:0]};
            end else begin
               v = {1'b1, 63'($urandom_range(1000, 0))} ^ {1'b0, 63'(len - k)};
            end
            queue_element(v, k == len - 1, 1'b0, none);
         end
      end
   endtask

   table_row_type directed_rows [] = '{
      '{ONE, 1'b1, 1'b1, '{10'd0, 1'b0}},
      '{ONE, 1'b0, 1'b1, '{10'd0, 1'b0}},
      '{TWO, 1'b1, 1'b1, '{10'd1, 1'b0}},
      '{ONE, 1'b0, 1'b1, '{10'd0, 1'b0}},
      '{TWO, 1'b0, 1'b1, '{10'd0, 1'b0}},
      '{TWO, 1'b0, 1'b1, '{10'd0, 1'b0}},
      '{TWO, 1'b1, 1'b1, '{10'd1, 1'b0}},
      '{NEG_ZERO, 1'b0, 1'b0, '{10'd0, 1'b0}},
      '{POS_ZERO, 1'b0, 1'b0, '{10'd0, 1'b0}},
      '{NEG_ZERO, 1'b1, 1'b1, '{10'd0, 1'b0}},
      '{QNAN, 1'b0, 1'b0, '{10'd0, 1'b0}},
      '{QNAN, 1'b1, 1'b1, '{10'd1, 1'b0}},
      '{NEG_INF, 1'b0, 1'b0, '{10'd0, 1'b0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '{10'd0, 1'b0}},
      '{POS_INF, 1'b0, 1'b0, '{10'd0, 1'b0}},
      '{POS_INF, 1'b1, 1'b1, '{10'd2, 1'b0}},
      '{64'h7FEF_FFFF_FFFF_FFFF, 1'b1, 1'b1, '{10'd0, 1'b0}}
   };

   initial begin
      int phase;
      int k;
      int queued;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      stored_count = 0;
      dropped_seen = 1'b0;
      mismatch_count = 0;
      cycle_count = 0;
      send_idle_pct = 32;
      recv_idle_pct = 61;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         queue_element(directed_rows[i].value_bits, directed_rows[i].is_last,
                       directed_rows[i].typed, directed_rows[i].result);
      // full store, then overflow with a dropped last element
      for (k = 0; k < MAX_ELEMENTS + 2; k++)
         queue_element(k < 3 ? NEG_INF : ONE, k == MAX_ELEMENTS + 1, 1'b1, '{10'd3, 1'b1});
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 61 : 0;
         recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 32 : 0;
         k = 0;
         while (k < 200) begin
            queue_random_array(queued);
            k += queued;
            while (pending_elements.size() > 64) @(posedge clock);
         end
      end
      wait_drained();
      while (expected_indexes.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end
endmodule

// File: files.f
+incdir+src
src/fmis_pkg.sv
src/fmis_ram.sv
src/first_max_index_search_unit.sv
verif/first_max_index_search_unit_test.sv
